>>> src/mad_pkg.sv
// Shared constants and types for the maximum antichain unit.
// No dependencies; imported by max_antichain_dilworth_unit.
`default_nettype none

package mad_pkg;

    // Default graph size and fixed field widths
    localparam int MAX_VERTICES_DEF = 16;
    localparam int ROW_W            = 16;
    localparam int VC_W             = 5;
    localparam int VERTEX_W         = 4;
    localparam int RESULT_LIMIT     = 16;
    localparam int CNT_W            = 4;
    localparam int VC_RESET         = 16;

    // Sequencer states
    typedef enum logic [3:0] {
        S_LOAD,
        S_COPY,
        S_WK,
        S_WKQ,
        S_WI,
        S_KROOT,
        S_KEVAL,
        S_KPOP,
        S_KAUG,
        S_CINIT,
        S_CSWEEP,
        S_CFIN,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

>>> src/max_antichain_dilworth_unit.sv
// Maximum antichain of a DAG: row loader, Warshall closure, Kuhn matching,
// Konig cover and result emitter around adjacency, work and stack memories.
// Depends on mad_pkg.
// Rate: one row per cycle while loading. After the last row the unit is busy with
// copy and closure (one work-memory read per row per pivot), then matching at one
// stack step per cycle, then cover sweeps over the rows (at most n+1 sweeps), then
// one result per cycle. The receiver cannot stall results. Reset clears control
// state and sets vertex_count to 16; memory contents are not reset.
`default_nettype none

module max_antichain_dilworth_unit #(
    parameter int MAX_VERTICES = mad_pkg::MAX_VERTICES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mad_pkg::ROW_W-1:0]    row_bits,
    input  logic                         last_row,
    output logic                         result_valid,
    output logic [mad_pkg::VERTEX_W-1:0] vertex,
    output logic                         last_vertex,
    input  logic                         cfg_write,
    input  logic [mad_pkg::VC_W-1:0]     cfg_data
);

    import mad_pkg::*;

    localparam int RW = MAX_VERTICES;
    localparam int IW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int SW = 2 * IW;

    // Lowest set bit of a row
    function automatic logic [IW-1:0] lowest(input logic [RW-1:0] m);
        logic [IW-1:0] r;
        r = '0;
        for (int b = RW - 1; b >= 0; b--) begin
            if (m[b]) r = IW'(b);
        end
        return r;
    endfunction

    // Memories
    logic [RW-1:0] adj_mem  [MAX_VERTICES];
    logic [RW-1:0] work_mem [MAX_VERTICES];
    logic [SW-1:0] stk_mem  [MAX_VERTICES];
    logic [RW-1:0] adj_q, work_q;
    logic [SW-1:0] stk_q;

    logic          adj_we, work_we, stk_we;
    logic [IW-1:0] adj_waddr, adj_raddr, work_waddr, work_raddr, stk_waddr, stk_raddr;
    logic [RW-1:0] adj_wdata, work_wdata;
    logic [SW-1:0] stk_wdata;

    always_ff @(posedge clk)
    begin
        if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
        adj_q <= adj_mem[adj_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (work_we) work_mem[work_waddr] <= work_wdata;
        work_q <= work_mem[work_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
        stk_q <= stk_mem[stk_raddr];
    end

    // Registers
    state_t        state_reg, state_next;
    logic [VC_W-1:0] vc_reg;
    logic [NW-1:0] row_cnt_reg, row_cnt_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [NW-1:0] k_reg, k_next;
    logic [NW-1:0] root_reg, root_next;
    logic [NW-1:0] j_reg, j_next;
    logic [NW-1:0] depth_reg, depth_next;
    logic [IW-1:0] v_reg, v_next;
    logic [IW-1:0] aug_reg, aug_next;
    logic [RW-1:0] rowk_reg, rowk_next;
    logic [RW-1:0] visited_reg, visited_next;
    logic [RW-1:0] matched_reg, matched_next;
    logic [RW-1:0] rr_reg, rr_next;
    logic [RW-1:0] anti_reg, anti_next;
    logic          changed_reg, changed_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] partner_reg [MAX_VERTICES];
    logic          part_we;
    logic [IW-1:0] part_waddr, part_wdata;
    logic          valid_reg, valid_next;
    logic [VERTEX_W-1:0] vertex_reg, vertex_next;
    logic          last_reg, last_next;

    // Derived values
    logic [NW-1:0] n_clamp, idx_m1, idx_p1;
    logic [RW-1:0] full, start_mask, pushable, cand, cols, reach, lm, lc, anti_rest;
    logic [IW-1:0] jj, pv, anti_lo;
    logic          chg, anti_last;

    always_comb
    begin
        n_clamp = (int'(vc_reg) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vc_reg);
        idx_m1  = idx_reg - 1'b1;
        idx_p1  = idx_reg + 1'b1;
        full       = ~({RW{1'b1}} << n_reg);
        start_mask = {RW{1'b1}} << j_reg;
        cols       = work_q & ~rr_reg;
        reach = '0;
        lm    = '0;
        lc    = '0;
        for (int b = 0; b < RW; b++) begin
            pushable[b] = !visited_reg[partner_reg[b]] && (depth_reg < NW'(MAX_VERTICES));
            if (matched_reg[b]) lm = lm | (RW'(1) << partner_reg[b]);
            if (matched_reg[b] && !rr_reg[b]) lc = lc | (RW'(1) << partner_reg[b]);
            if (matched_reg[b] && cols[b]) reach = reach | (RW'(1) << partner_reg[b]);
        end
        cand      = work_q & start_mask & (~matched_reg | pushable);
        jj        = lowest(cand);
        pv        = partner_reg[jj];
        anti_lo   = lowest(anti_reg);
        anti_rest = anti_reg & ~(RW'(1) << anti_lo);
        anti_last = (anti_rest == '0) || (cnt_reg == CNT_W'(RESULT_LIMIT - 1));
    end

    // Next state and datapath control
    always_comb
    begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        root_next    = root_reg;
        j_next       = j_reg;
        depth_next   = depth_reg;
        v_next       = v_reg;
        aug_next     = aug_reg;
        rowk_next    = rowk_reg;
        visited_next = visited_reg;
        matched_next = matched_reg;
        rr_next      = rr_reg;
        anti_next    = anti_reg;
        changed_next = changed_reg;
        cnt_next     = cnt_reg;
        valid_next   = 1'b0;
        vertex_next  = vertex_reg;
        last_next    = 1'b0;
        adj_we     = 1'b0;
        adj_waddr  = row_cnt_reg[IW-1:0];
        adj_wdata  = RW'(row_bits);
        adj_raddr  = idx_reg[IW-1:0];
        work_we    = 1'b0;
        work_waddr = idx_reg[IW-1:0];
        work_wdata = work_q;
        work_raddr = idx_reg[IW-1:0];
        stk_we     = 1'b0;
        stk_waddr  = IW'(depth_reg - 1'b1);
        stk_wdata  = {v_reg, jj};
        stk_raddr  = IW'(depth_reg - 2'd2);
        part_we    = 1'b0;
        part_waddr = jj;
        part_wdata = v_reg;
        chg        = changed_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                // Store a row; on the last row set up the run
                if (start) begin
                    if (row_cnt_reg < NW'(MAX_VERTICES)) begin
                        adj_we       = 1'b1;
                        row_cnt_next = row_cnt_reg + 1'b1;
                    end
                    if (last_row) begin
                        row_cnt_next = '0;
                        n_next       = n_clamp;
                        matched_next = '0;
                        visited_next = '0;
                        rr_next      = '0;
                        idx_next     = '0;
                        if (n_clamp != '0) state_next = S_COPY;
                    end
                end
            end
            S_COPY:
            begin
                // Copy masked adjacency into the work memory
                if (idx_reg != '0) begin
                    work_we    = 1'b1;
                    work_waddr = idx_m1[IW-1:0];
                    work_wdata = adj_q & full;
                end
                if (idx_reg == n_reg) begin
                    k_next     = '0;
                    state_next = S_WK;
                end else begin
                    idx_next = idx_p1;
                end
            end
            S_WK:
            begin
                work_raddr = k_reg[IW-1:0];
                state_next = S_WKQ;
            end
            S_WKQ:
            begin
                rowk_next  = work_q;
                work_raddr = '0;
                idx_next   = '0;
                state_next = S_WI;
            end
            S_WI:
            begin
                // Merge the pivot row into every row reaching the pivot
                work_we    = 1'b1;
                work_waddr = idx_reg[IW-1:0];
                work_wdata = work_q | (work_q[k_reg[IW-1:0]] ? rowk_reg : '0);
                work_raddr = idx_p1[IW-1:0];
                if (idx_reg == n_reg - 1'b1) begin
                    if (k_reg == n_reg - 1'b1) begin
                        root_next  = '0;
                        state_next = S_KROOT;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_WK;
                    end
                end else begin
                    idx_next = idx_p1;
                end
            end
            S_KROOT:
            begin
                // Start an augmenting search from the next left vertex
                if (root_reg == n_reg) begin
                    state_next = S_CINIT;
                end else begin
                    v_next       = root_reg[IW-1:0];
                    j_next       = '0;
                    depth_next   = NW'(1);
                    visited_next = RW'(1) << root_reg[IW-1:0];
                    work_raddr   = root_reg[IW-1:0];
                    root_next    = root_reg + 1'b1;
                    state_next   = S_KEVAL;
                end
            end
            S_KEVAL:
            begin
                if (cand != '0 && !matched_reg[jj]) begin
                    // Free column: claim it and unwind the stack
                    part_we      = 1'b1;
                    matched_next = matched_reg | (RW'(1) << jj);
                    if (depth_reg > NW'(1)) begin
                        aug_next   = IW'(depth_reg - 2'd2);
                        state_next = S_KAUG;
                    end else begin
                        state_next = S_KROOT;
                    end
                end else if (cand != '0) begin
                    // Descend into the column's partner
                    stk_we       = 1'b1;
                    visited_next = visited_reg | (RW'(1) << pv);
                    v_next       = pv;
                    j_next       = '0;
                    depth_next   = depth_reg + 1'b1;
                    work_raddr   = pv;
                    state_next   = S_KEVAL;
                end else begin
                    // Dead end: drop a level
                    depth_next = depth_reg - 1'b1;
                    if (depth_reg == NW'(1)) state_next = S_KROOT;
                    else                     state_next = S_KPOP;
                end
            end
            S_KPOP:
            begin
                v_next     = stk_q[SW-1:IW];
                j_next     = NW'(stk_q[IW-1:0]) + 1'b1;
                work_raddr = stk_q[SW-1:IW];
                state_next = S_KEVAL;
            end
            S_KAUG:
            begin
                part_we      = 1'b1;
                part_waddr   = stk_q[IW-1:0];
                part_wdata   = stk_q[SW-1:IW];
                matched_next = matched_reg | (RW'(1) << stk_q[IW-1:0]);
                stk_raddr    = aug_reg - 1'b1;
                aug_next     = aug_reg - 1'b1;
                if (aug_reg == '0) state_next = S_KROOT;
            end
            S_CINIT:
            begin
                visited_next = full & ~lm;
                rr_next      = '0;
                changed_next = 1'b0;
                idx_next     = '0;
                work_raddr   = '0;
                state_next   = S_CSWEEP;
            end
            S_CSWEEP:
            begin
                // Spread reach along alternating paths, one row a cycle
                if (visited_reg[idx_reg[IW-1:0]] && cols != '0) begin
                    rr_next      = rr_reg | cols;
                    visited_next = visited_reg | reach;
                    chg          = 1'b1;
                end
                if (idx_reg == n_reg - 1'b1) begin
                    idx_next     = '0;
                    changed_next = 1'b0;
                    work_raddr   = '0;
                    if (!chg) state_next = S_CFIN;
                end else begin
                    idx_next     = idx_p1;
                    changed_next = chg;
                    work_raddr   = idx_p1[IW-1:0];
                end
            end
            S_CFIN:
            begin
                anti_next  = full & ~(lc | (matched_reg & rr_reg));
                cnt_next   = '0;
                state_next = ((full & ~(lc | (matched_reg & rr_reg))) == '0) ? S_LOAD : S_EMIT;
            end
            S_EMIT:
            begin
                // Transfer one antichain vertex per cycle
                valid_next  = 1'b1;
                vertex_next = VERTEX_W'(anti_lo);
                last_next   = anti_last;
                anti_next   = anti_rest;
                cnt_next    = cnt_reg + 1'b1;
                if (anti_last) state_next = S_LOAD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= S_LOAD;
            vc_reg      <= VC_W'(VC_RESET);
            row_cnt_reg <= '0;
            n_reg       <= '0;
            idx_reg     <= '0;
            k_reg       <= '0;
            root_reg    <= '0;
            j_reg       <= '0;
            depth_reg   <= '0;
            aug_reg     <= '0;
            matched_reg <= '0;
            visited_reg <= '0;
            rr_reg      <= '0;
            anti_reg    <= '0;
            changed_reg <= 1'b0;
            cnt_reg     <= '0;
            valid_reg   <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_write) vc_reg <= cfg_data;
            row_cnt_reg <= row_cnt_next;
            n_reg       <= n_next;
            idx_reg     <= idx_next;
            k_reg       <= k_next;
            root_reg    <= root_next;
            j_reg       <= j_next;
            depth_reg   <= depth_next;
            aug_reg     <= aug_next;
            matched_reg <= matched_next;
            visited_reg <= visited_next;
            rr_reg      <= rr_next;
            anti_reg    <= anti_next;
            changed_reg <= changed_next;
            cnt_reg     <= cnt_next;
            valid_reg   <= valid_next;
            last_reg    <= last_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        rowk_reg   <= rowk_next;
        vertex_reg <= vertex_next;
        if (part_we) partner_reg[part_waddr] <= part_wdata;
    end

    assign busy         = (state_reg != S_LOAD);
    assign result_valid = valid_reg;
    assign vertex       = vertex_reg;
    assign last_vertex  = last_reg;

    // Checks
    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_EMIT))
        else $error("result strobe without emit state");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= NW'(MAX_VERTICES))
        else $error("search stack overflow");

    a_row_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_cnt_reg <= NW'(MAX_VERTICES))
        else $error("row counter out of range");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_vertex) |=> !result_valid)
        else $error("result after final vertex");

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for max_antichain_dilworth_unit: loads directed and random DAG or noise matrices,
// predicts each maximum antichain and checks every emitted vertex in order.
// Depends on mad_pkg and the RTL of max_antichain_dilworth_unit.
`default_nettype none

// Holds the expected antichain vertices and the graph state that predicts them
class antichain_board;
    logic [15:0] adj_rows [16];
    int          row_ptr;
    int          vcount;
    logic [15:0] closure [16];
    int          mate [16];
    logic [15:0] mated;
    logic [15:0] seen;
    int          stk_v [16];
    int          stk_c [16];
    logic [4:0]  exp_q [$];
    int          errors;

    function new();
        row_ptr = 0;
        vcount  = mad_pkg::VC_RESET;
        errors  = 0;
        foreach (adj_rows[i]) adj_rows[i] = '0;
    endfunction

    function void report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endfunction

    function void set_vcount(int v);
        vcount = v;
    endfunction

    // Kuhn augmenting search from one left vertex, as an explicit stack
    function void augment(int root, int n);
        int depth, v, j, f;
        bit pushed;
        depth = 1;
        seen = 16'(1) << root;
        stk_v[0] = root;
        stk_c[0] = 0;
        while (depth > 0)
        begin
            v = stk_v[depth-1];
            j = stk_c[depth-1];
            pushed = 0;
            while (j < n)
            begin
                if (closure[v][j])
                begin
                    if (!mated[j])
                    begin
                        stk_c[depth-1] = j;
                        for (f = 0; f < depth; f++)
                        begin
                            mate[stk_c[f]] = stk_v[f];
                            mated[stk_c[f]] = 1'b1;
                        end
                        return;
                    end
                    if (!seen[mate[j]] && depth < 16)
                    begin
                        stk_c[depth-1] = j;
                        seen[mate[j]] = 1'b1;
                        stk_v[depth] = mate[j];
                        stk_c[depth] = 0;
                        depth++;
                        pushed = 1;
                        break;
                    end
                end
                j++;
            end
            if (!pushed)
            begin
                depth--;
                if (depth > 0)
                    stk_c[depth-1]++;
            end
        end
    endfunction

    // Note one accepted row; on the last row queue the expected antichain
    function void note_row(logic [15:0] row, logic last);
        int n, i, k, j;
        logic [15:0] full, left_m, left_cov, reached, cols, anti;
        bit changed;
        int last_idx;
        logic [4:0] item;
        if (row_ptr < 16)
        begin
            adj_rows[row_ptr] = row;
            row_ptr++;
        end
        if (!last)
            return;
        row_ptr = 0;
        n = (vcount > 16) ? 16 : vcount;
        if (n == 0)
            return;
        full = (n == 16) ? 16'hFFFF : ((16'(1) << n) - 16'd1);
        for (i = 0; i < 16; i++)
        begin
            closure[i] = (i < n) ? (adj_rows[i] & full) : '0;
            mate[i] = 0;
        end
        // Warshall closure
        for (k = 0; k < n; k++)
            for (i = 0; i < n; i++)
                if (closure[i][k])
                    closure[i] |= closure[k];
        mated = '0;
        for (i = 0; i < n; i++)
            augment(i, n);
        left_m = '0;
        for (j = 0; j < n; j++)
            if (mated[j])
                left_m[mate[j]] = 1'b1;
        // Alternating paths from free left vertices
        seen = full & ~left_m;
        reached = '0;
        changed = 1;
        while (changed)
        begin
            changed = 0;
            for (i = 0; i < n; i++)
            begin
                if (!seen[i])
                    continue;
                cols = closure[i] & full & ~reached;
                if (cols == 0)
                    continue;
                reached |= cols;
                changed = 1;
                for (j = 0; j < n; j++)
                    if (cols[j] && mated[j])
                        seen[mate[j]] = 1'b1;
            end
        end
        left_cov = '0;
        for (j = 0; j < n; j++)
            if (mated[j] && !reached[j])
                left_cov[mate[j]] = 1'b1;
        anti = full & ~(left_cov | (mated & reached));
        last_idx = -1;
        for (i = 0; i < n; i++)
            if (anti[i])
                last_idx = i;
        for (i = 0; i < n; i++)
            if (anti[i])
            begin
                item = {4'(i), (i == last_idx)};
                exp_q.insert(exp_q.size(), item);
            end
    endfunction

    function void check_result(logic [3:0] vtx, logic lastv);
        logic [4:0] want;
        if (exp_q.size() == 0)
        begin
            report($sformatf("unexpected vertex %0d", vtx));
            return;
        end
        want = exp_q.pop_front();
        if (vtx !== want[4:1])
            report($sformatf("vertex %0d, expected %0d", vtx, want[4:1]));
        if (lastv !== want[0])
            report($sformatf("last_vertex %b, expected %b", lastv, want[0]));
    endfunction
endclass

module tb;
    import mad_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [ROW_W-1:0]    row_bits;
    logic                last_row;
    logic                result_valid;
    logic [VERTEX_W-1:0] vertex;
    logic                last_vertex;
    logic                cfg_write;
    logic [VC_W-1:0]     cfg_data;

    antichain_board board;
    int             rows_sent;
    int             idle_cycles;
    int             rank [16];
    bit             burst;

    max_antichain_dilworth_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .row_bits     (row_bits),
        .last_row     (last_row),
        .result_valid (result_valid),
        .vertex       (vertex),
        .last_vertex  (last_vertex),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Check every emitted vertex at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            board.check_result(vertex, last_vertex);
    end

    // Drop the run when neither side moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || result_valid || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Transfer one row, after an optional random gap; start stays high on return
    task automatic send_row(input logic [15:0] row, input logic last);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            start    <= 1'b0;
            row_bits <= 16'($urandom());
            last_row <= 1'($urandom());
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        row_bits <= row;
        last_row <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_row(row, last);
        rows_sent++;
    endtask

    // Hold until every expected vertex has come and the unit is quiet
    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (board.exp_q.size() != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_vcount(input int v);
        wait_quiet();
        cfg_write <= 1'b1;
        cfg_data  <= 5'(v);
        @(posedge clk);
        cfg_write <= 1'b0;
        board.set_vcount(v & 31);
    endtask

    // Shuffle a topological order so that edges only run forward in it
    task automatic shuffle_ranks();
        int i, k, t;
        for (i = 0; i < 16; i++)
            rank[i] = i;
        for (i = 15; i > 0; i--)
        begin
            k = $urandom_range(0, i);
            t = rank[i];
            rank[i] = rank[k];
            rank[k] = t;
        end
    endtask

    function automatic logic [15:0] dag_row(int i, int density);
        logic [15:0] r;
        int j;
        r = '0;
        for (j = 0; j < 16; j++)
            if (rank[j] > rank[i] && $urandom_range(0, 99) < density)
                r[j] = 1'b1;
        return r;
    endfunction

    // Send a graph of count rows: mostly DAGs, sometimes arbitrary noise
    task automatic send_graph(input int count, input bit noisy);
        int i, density;
        shuffle_ranks();
        density = $urandom_range(5, 70);
        for (i = 0; i < count; i++)
            send_row(noisy ? 16'($urandom()) : dag_row(i % 16, density), i == count - 1);
    endtask

    initial
    begin
        int i, n, cnt;
        board     = new();
        rows_sent = 0;
        burst     = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        row_bits  = '0;
        last_row  = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: no edges at all, every vertex emitted (fills every row)
        for (i = 0; i < 16; i++)
            send_row(16'h0000, i == 15);
        // Directed: full chain, too many rows, all-ones cyclic rows
        send_row(16'hFFFE, 1'b0);
        for (i = 1; i < 15; i++)
            send_row(16'hFFFF << (i + 1), 1'b0);
        send_row(16'h0000, 1'b1);
        wait_quiet();
        burst = 1'b1;
        for (i = 0; i < 18; i++)
            send_row(16'hFFFF, i == 17);
        burst = 1'b0;
        // Directed: single vertex, empty graph, count above the limit
        write_vcount(1);
        send_row(16'hFFFF, 1'b1);
        write_vcount(0);
        send_row(16'h1234, 1'b1);
        write_vcount(31);
        send_graph(16, 1'b0);
        // Directed: partial load keeps older rows
        write_vcount(16);
        send_graph(5, 1'b0);

        // Random graphs over changing sizes
        while (rows_sent < 200)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                cnt = $urandom_range(0, 9);
                n = (cnt == 0) ? 0 : (cnt == 1) ? $urandom_range(17, 31) : $urandom_range(1, 16);
                write_vcount(n);
            end
            else if ($urandom_range(0, 4) == 0)
                wait_quiet();
            burst = ($urandom_range(0, 3) == 0);
            n = (board.vcount > 16) ? 16 : board.vcount;
            cnt = $urandom_range(0, 9);
            if (cnt == 0)
                cnt = $urandom_range(1, 20);
            else
                cnt = (n == 0) ? 1 : n;
            send_graph(cnt, $urandom_range(0, 7) == 0);
        end

        wait_quiet();
        repeat (50) @(posedge clk);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire
